[rtl/falru_pkg.sv]
// ----------------------------------------------------------------------------
// falru_pkg
// Shared types and constants of the fully associative translation buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package falru_pkg;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_EVICT  = 2'd2;

	// Replacement only considers stamps strictly below this limit.
	localparam int          LIMIT_W     = 20;
	localparam logic [19:0] STAMP_LIMIT = 20'd999999;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [19:0] access_count;
		logic [7:0]  virt_page;
		logic [15:0] phys_page;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [15:0] found_page;
	} rsp_t;

endpackage

`default_nettype wire

[rtl/falru_mem.sv]
// ----------------------------------------------------------------------------
// falru_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module falru_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 44
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] ram_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			ram_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= ram_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/falru_seq.sv]
// ----------------------------------------------------------------------------
// falru_seq
// Sequencer: walks the entry memory one line per cycle for lookup, evict and
// replacement choice, and holds the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module falru_seq import falru_pkg::*; #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 8,
	parameter int FRAME_BITS = 16,
	parameter int STAMP_BITS = 20
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       req_valid,
	output logic                                            req_stall,
	input  wire req_t                                       req_data,
	input  wire logic                                       out_free,
	output logic                                            res_push,
	output rsp_t                                            res_data,
	output logic                                            mem_we,
	output logic [$clog2(ENTRIES)-1:0]                      mem_waddr,
	output logic [KEY_BITS+FRAME_BITS+STAMP_BITS-1:0]       mem_wdata,
	output logic                                            mem_re,
	output logic [$clog2(ENTRIES)-1:0]                      mem_raddr,
	input  wire logic [KEY_BITS+FRAME_BITS+STAMP_BITS-1:0]  mem_rdata
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	logic [1:0]            state_q;
	logic [1:0]            op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [ENTRIES-1:0]    valid_q;
	logic [IDX_W-1:0]      iss_q;
	logic                  iss_done_q;
	logic                  chk_vld_s1;
	logic [IDX_W-1:0]      chk_idx_s1;
	logic [LIMIT_W-1:0]    best_q;
	logic [IDX_W-1:0]      victim_q;
	rsp_t                  res_q;

	logic [31:0]           key_ext, frame_ext, stamp_ext;
	logic [KEY_BITS-1:0]   in_key;
	logic [FRAME_BITS-1:0] in_frame;
	logic [STAMP_BITS-1:0] in_stamp;
	logic                  any_free;
	logic [IDX_W-1:0]      first_free;
	logic                  accept;
	logic [KEY_BITS-1:0]   rd_key;
	logic [FRAME_BITS-1:0] rd_frame;
	logic [STAMP_BITS-1:0] rd_stamp;
	logic [31:0]           rd_stamp_ext, rd_frame_ext;
	logic                  hit_now, last_chk;
	logic [LIMIT_W-1:0]    cand_best;
	logic [IDX_W-1:0]      cand_victim;

	assign key_ext   = 32'(req_data.virt_page);
	assign frame_ext = 32'(req_data.phys_page);
	assign stamp_ext = 32'(req_data.access_count);
	assign in_key    = key_ext[KEY_BITS-1:0];
	assign in_frame  = frame_ext[FRAME_BITS-1:0];
	assign in_stamp  = stamp_ext[STAMP_BITS-1:0];

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	assign any_free = ~&valid_q;
	always_comb begin
		first_free = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				first_free = IDX_W'(i);
			end
		end
	end

	assign rd_key       = mem_rdata[KEY_BITS+FRAME_BITS+STAMP_BITS-1 -: KEY_BITS];
	assign rd_frame     = mem_rdata[FRAME_BITS+STAMP_BITS-1 -: FRAME_BITS];
	assign rd_stamp     = mem_rdata[STAMP_BITS-1:0];
	assign rd_stamp_ext = 32'(rd_stamp);
	assign rd_frame_ext = 32'(rd_frame);

	assign hit_now  = chk_vld_s1 && valid_q[chk_idx_s1] && (rd_key == key_q);
	assign last_chk = chk_vld_s1 && (chk_idx_s1 == LAST_IDX);

	// Running minimum over stamps below the limit; the earliest index wins ties.
	always_comb begin
		cand_best   = best_q;
		cand_victim = victim_q;
		if (chk_vld_s1 && (rd_stamp_ext < 32'(best_q))) begin
			cand_best   = rd_stamp_ext[LIMIT_W-1:0];
			cand_victim = chk_idx_s1;
		end
	end

	always_comb begin
		mem_re    = (state_q == ST_SCAN) && !iss_done_q;
		mem_raddr = iss_q;
		mem_we    = 1'b0;
		mem_waddr = first_free;
		mem_wdata = {in_key, in_frame, in_stamp};
		if (state_q == ST_IDLE) begin
			mem_we = accept && (req_data.opcode == OP_INSERT) && any_free;
		end else if (state_q == ST_SCAN) begin
			if (op_q == OP_LOOKUP && hit_now) begin
				mem_we    = 1'b1;
				mem_waddr = chk_idx_s1;
				mem_wdata = {rd_key, rd_frame, stamp_q};
			end else if (op_q == OP_INSERT && last_chk) begin
				mem_we    = 1'b1;
				mem_waddr = cand_victim;
				mem_wdata = {key_q, frame_q, stamp_q};
			end
		end
	end

	assign res_push = (state_q == ST_RESP) && out_free;
	assign res_data = res_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			iss_q      <= '0;
			iss_done_q <= 1'b0;
			chk_vld_s1 <= 1'b0;
			op_q       <= OP_LOOKUP;
		end else begin
			chk_vld_s1 <= mem_re;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q       <= req_data.opcode;
						iss_q      <= '0;
						iss_done_q <= 1'b0;
						case (req_data.opcode)
							OP_LOOKUP, OP_EVICT: state_q <= ST_SCAN;
							OP_INSERT: begin
								if (any_free) begin
									valid_q[first_free] <= 1'b1;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SCAN: begin
					if (mem_re) begin
						iss_q <= iss_q + 1'b1;
						if (iss_q == LAST_IDX) begin
							iss_done_q <= 1'b1;
						end
					end
					case (op_q)
						OP_LOOKUP: begin
							if (hit_now || last_chk) begin
								state_q <= ST_RESP;
							end
						end
						OP_EVICT: begin
							if (chk_vld_s1 && (rd_frame == frame_q)) begin
								valid_q[chk_idx_s1] <= 1'b0;
							end
							if (last_chk) begin
								state_q <= ST_IDLE;
							end
						end
						OP_INSERT: begin
							if (last_chk) begin
								valid_q[cand_victim] <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		chk_idx_s1 <= iss_q;
		if (accept) begin
			key_q    <= in_key;
			frame_q  <= in_frame;
			stamp_q  <= in_stamp;
			best_q   <= STAMP_LIMIT;
			victim_q <= '0;
		end else if (state_q == ST_SCAN) begin
			best_q   <= cand_best;
			victim_q <= cand_victim;
		end
		if (state_q == ST_SCAN && op_q == OP_LOOKUP) begin
			if (hit_now) begin
				res_q.hit        <= 1'b1;
				res_q.found_page <= rd_frame_ext[15:0];
			end else if (last_chk) begin
				res_q.hit        <= 1'b0;
				res_q.found_page <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/fully_associative_tlb_lru_top.sv]
// ----------------------------------------------------------------------------
// fully_associative_tlb_lru_top
// Fully associative translation buffer with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_data and are taken when req_stall is low.
// Each request is a lookup, an insert or an evict. Only a lookup returns a
// response, on rsp_valid/rsp_data, held until rsp_stall is low.
// Lines live in a single-port-read, single-port-write memory with registered
// read data; the sequencer reads one line per cycle.
// An insert into a buffer with a free line writes the first free line as it
// is taken. A full insert and an evict walk every line. A lookup walks until
// the first match or the last line, and its response then goes to the output
// register once that register is free.
// A new request is taken only once the previous one has finished; a response
// waiting in the output register does not block inserts or evicts.
// If the receiver stalls, a second lookup result waits in the sequencer and
// req_stall stays high until the output register frees up.
// Reset clears all valid bits and the handshake state; the line memory needs
// no clearing, since only valid lines are ever matched or replaced.
// ----------------------------------------------------------------------------
`default_nettype none

module fully_associative_tlb_lru_top import falru_pkg::*; #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 8,
	parameter int FRAME_BITS = 16,
	parameter int STAMP_BITS = 20
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req_data,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp_data
);

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int LINE_W = KEY_BITS + FRAME_BITS + STAMP_BITS;

	logic              mem_we, mem_re;
	logic [IDX_W-1:0]  mem_waddr, mem_raddr;
	logic [LINE_W-1:0] mem_wdata, mem_rdata;
	logic              out_free, res_push;
	rsp_t              res_data;
	logic              out_valid_q;
	rsp_t              out_q;

	falru_mem #(
		.DEPTH(ENTRIES),
		.WIDTH(LINE_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	falru_seq #(
		.ENTRIES   (ENTRIES),
		.KEY_BITS  (KEY_BITS),
		.FRAME_BITS(FRAME_BITS),
		.STAMP_BITS(STAMP_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.out_free (out_free),
		.res_push (res_push),
		.res_data (res_data),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	assign out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q <= res_data;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	// A result is never pushed over one that the receiver has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (!out_valid_q || !rsp_stall))
		else $error("response register overwritten");

	// A miss always reports page zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_data.hit) |-> (rsp_data.found_page == 16'd0))
		else $error("miss with nonzero page");

	// A lookup always occupies the sequencer for the following cycle.
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req_data.opcode == OP_LOOKUP) |=> req_stall)
		else $error("lookup did not hold off the next request");

endmodule

`default_nettype wire
